@@ sv/dbc_pkg.sv @@
// Shared types, constants and the brightness/contrast arithmetic for the
// line-average deinterlacer. No dependencies.
package dbc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINE_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_DEINTERLACE   = 3'd2,
    CFG_BRIGHTNESS    = 3'd3,
    CFG_CONTRAST_GAIN = 3'd4
  } cfg_idx_e;

  localparam logic [12:0] LineWidthRst   = 13'd1920;
  localparam logic [12:0] FrameHeightRst = 13'd1080;
  localparam logic [8:0]  BrightnessRst  = 9'd128;
  localparam logic [7:0]  GainRst        = 8'd32;
  localparam logic [12:0] MaxFrameHeight = 13'd4096;

  localparam logic [7:0]          DiffThresh   = 8'd16;
  localparam logic signed [10:0]  BrightOffset = 11'sd384;
  localparam logic [9:0]          BrightBias   = 10'd128;
  localparam logic [7:0]          PixMax       = 8'd255;

  // one accepted word waiting to be turned into its results
  typedef struct packed {
    logic [7:0]  pix;
    logic [11:0] row;
    logic [11:0] col;
    logic        last_frame;
    logic        mid_pend;   // interpolated odd sample still to send
    logic        main_pend;  // own sample still to send
  } s1_t;

  // ((x + ((b-384)>>1)) * g + (((b+128)>>1)<<5)) >> 5, clamped to 0..255
  function automatic logic [7:0] adjust(input logic [7:0] x, input logic [8:0] b,
                                        input logic [7:0] g);
    logic signed [10:0] b1;
    logic signed [10:0] xs;
    logic        [9:0]  bsum;
    logic        [13:0] b2;
    logic signed [19:0] prod;
    logic signed [19:0] acc;
    logic signed [19:0] v;
    logic        [7:0]  res;
    b1   = ($signed({2'b00, b}) - BrightOffset) >>> 1;
    xs   = $signed({3'b000, x}) + b1;
    bsum = {1'b0, b} + BrightBias;
    b2   = {bsum[9:1], 5'b00000};
    prod = 20'(xs) * $signed({12'd0, g});
    acc  = prod + $signed({6'd0, b2});
    v    = acc >>> 5;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > $signed({12'd0, PixMax})) begin
      res = PixMax;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

@@ sv/deinterlace_bright_contrast.sv @@
// Line-average deinterlacer with brightness/contrast, top level.
// Depends on dbc_pkg.
//
// Takes one luma word per cycle while in_stall_o is low. Every word gives one
// result but in the cases below, and the block then runs at one word per cycle
// while out_stall_i is low. Under deinterlacing an odd row is held in the odd
// line store and gives no result; the even row below it gives two results per
// word (the corrected odd sample, then its own), and both pass through the
// single multiplier and output register, so such a row takes its next word only
// as the second result is emitted. Results pass through the stage 1 register and
// then the output register. Both line stores are single-port synchronous RAMs
// of MAX_LINE_WIDTH bytes, read and written at the accept edge; they have no
// clearing pass and are valid once the rows they hold have been written.
// Configuration writes are taken in any cycle and should only be made idle.
module deinterlace_bright_contrast #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dbc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dbc_pkg::CfgDataW-1:0]  cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    pixel_in_i,
  input  logic                          frame_start_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    pixel_out_o,
  output logic [11:0]                   out_row_o,
  output logic [11:0]                   out_column_o,
  output logic                          last_of_item_o,
  output logic                          last_of_frame_o
);
  import dbc_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned MaxW = (MAX_LINE_WIDTH < 4096) ? MAX_LINE_WIDTH : 4096;

  // configuration registers
  logic [12:0] line_width_q, frame_height_q;
  logic        deint_q;
  logic [8:0]  bright_q;
  logic [7:0]  gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthRst;
      frame_height_q <= FrameHeightRst;
      deint_q        <= 1'b0;
      bright_q       <= BrightnessRst;
      gain_q         <= GainRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_WIDTH:    line_width_q   <= cfg_data_i;
        CFG_FRAME_HEIGHT:  frame_height_q <= cfg_data_i;
        CFG_DEINTERLACE:   deint_q        <= cfg_data_i[0];
        CFG_BRIGHTNESS:    bright_q       <= cfg_data_i[8:0];
        CFG_CONTRAST_GAIN: gain_q         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [12:0] w, h, pairs_end;
  always_comb begin
    if (line_width_q == 13'd0) begin
      w = 13'd1;
    end else if (line_width_q > 13'(MaxW)) begin
      w = 13'(MaxW);
    end else begin
      w = line_width_q;
    end
    if (frame_height_q == 13'd0) begin
      h = 13'd1;
    end else if (frame_height_q > MaxFrameHeight) begin
      h = MaxFrameHeight;
    end else begin
      h = frame_height_q;
    end
    pairs_end = {h[12:1], 1'b0};
  end

  // position counters and per-word decisions
  logic [11:0] col_q, col_d, row_q, row_d;
  logic [11:0] row_c, col_c;
  logic [12:0] col_inc, row_inc;
  logic        hold_odd, fix_even, last_frame_c;
  logic        in_accept;
  logic [12:0] col_ext;
  logic [AW-1:0] addr;

  always_comb begin
    row_c = frame_start_i ? 12'd0 : row_q;
    if (frame_start_i || ({1'b0, col_q} >= w)) begin
      col_c = 12'd0;
    end else begin
      col_c = col_q;
    end
    col_inc = {1'b0, col_c} + 13'd1;
    row_inc = {1'b0, row_c} + 13'd1;
    hold_odd = row_c[0] && deint_q && ({2'b00, row_c} + 14'd3 <= {1'b0, pairs_end});
    fix_even = !row_c[0] && deint_q && (row_c >= 12'd2) &&
               ({2'b00, row_c} + 14'd2 <= {1'b0, pairs_end});
    last_frame_c = ({1'b0, row_c} >= h - 13'd1) && ({1'b0, col_c} == w - 13'd1);
    if (col_inc >= w) begin
      col_d = 12'd0;
      row_d = (row_inc >= h) ? 12'd0 : row_inc[11:0];
    end else begin
      col_d = col_inc[11:0];
      row_d = row_c;
    end
    col_ext = {1'b0, col_c};
    addr    = col_ext[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 12'd0;
      row_q <= 12'd0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores: read old content and write at the accept edge
  logic [7:0] even_mem [MAX_LINE_WIDTH];
  logic [7:0] odd_mem  [MAX_LINE_WIDTH];
  logic [7:0] even_rd_q, odd_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      even_rd_q <= even_mem[addr];
      if (!row_c[0]) begin
        even_mem[addr] <= pixel_in_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      odd_rd_q <= odd_mem[addr];
      if (hold_odd) begin
        odd_mem[addr] <= pixel_in_i;
      end
    end
  end

  // stage 1: word awaiting emission
  logic s1_valid_q;
  s1_t  s1_q, s1_d;
  logic can_go, s1_done, emit;

  assign can_go  = !out_valid_o || !out_stall_i;
  assign s1_done = s1_valid_q && (!s1_q.main_pend || (can_go && !s1_q.mid_pend));
  assign emit    = s1_valid_q && s1_q.main_pend && can_go;

  assign in_stall_o = s1_valid_q && !s1_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_d = s1_q;
    if (in_accept) begin
      s1_d.pix        = pixel_in_i;
      s1_d.row        = row_c;
      s1_d.col        = col_c;
      s1_d.last_frame = last_frame_c;
      s1_d.mid_pend   = fix_even;
      s1_d.main_pend  = !hold_odd;
    end else if (emit && s1_q.mid_pend) begin
      s1_d.mid_pend = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // odd sample correction and the shared brightness/contrast path
  logic [7:0] avg, mid, diff, x_sel;
  always_comb begin
    avg   = {1'b0, even_rd_q[7:1]} + {1'b0, s1_q.pix[7:1]};
    diff  = (avg > odd_rd_q) ? (avg - odd_rd_q) : (odd_rd_q - avg);
    mid   = (diff >= DiffThresh) ? avg : odd_rd_q;
    x_sel = s1_q.mid_pend ? mid : s1_q.pix;
  end

  // output register
  logic        out_valid_q;
  logic [7:0]  pix_out_q;
  logic [11:0] row_out_q, col_out_q;
  logic        last_item_q, last_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_out_q    <= adjust(x_sel, bright_q, gain_q);
      row_out_q    <= s1_q.mid_pend ? (s1_q.row - 12'd1) : s1_q.row;
      col_out_q    <= s1_q.col;
      last_item_q  <= !s1_q.mid_pend;
      last_frame_q <= !s1_q.mid_pend && s1_q.last_frame;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_out_o     = pix_out_q;
  assign out_row_o       = row_out_q;
  assign out_column_o    = col_out_q;
  assign last_of_item_o  = last_item_q;
  assign last_of_frame_o = last_frame_q;

`ifndef NO_ASSERTIONS
  // a pending corrected sample always comes with its own sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.mid_pend |-> s1_q.main_pend)
    else $error("corrected sample without its even sample");

  // corrected samples belong to odd rows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !last_item_q |-> row_out_q[0])
    else $error("corrected sample on an even row");

  // the even sample follows its corrected sample straight away, same column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !last_item_q && !out_stall_i |=>
      out_valid_q && last_item_q && (col_out_q == $past(col_out_q)))
    else $error("even sample did not follow corrected sample");

  // end of frame is only flagged on the last result of a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_frame_q |-> last_item_q)
    else $error("frame end flagged on a corrected sample");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking bench for deinterlace_bright_contrast: a short scripted run, then
// randomised register settings and pixel frames, checked by an in-bench predictor.
// Depends on dbc_pkg and the top level RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbc_pkg::*;

  localparam int MaxLine       = 4096;
  localparam int IdlePct       = 34;
  localparam int SettleCycles  = 6;
  localparam int WatchdogLimit = 2000;
  localparam int RandPhases    = 14;
  localparam int PhaseWords    = 125;
  localparam int CalmPhase     = 3;
  localparam int NumScript     = 25;

  typedef struct packed {
    logic [7:0]  pix;
    logic [11:0] row;
    logic [11:0] col;
    logic        last_item;
    logic        last_frame;
  } sample_t;

  typedef enum logic {ROW_WORD, ROW_REGS} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  pix;
    logic        fs;
    logic        typed;
    logic [7:0]  want;
    logic [12:0] width;
    logic [12:0] height;
    logic        di;
    logic [8:0]  bright;
    logic [7:0]  gain;
  } script_row_t;

  // kind, pixel, frame start, typed, wanted pixel, width, height, deint, bright, gain
  localparam script_row_t Script [NumScript] = '{
    '{ROW_WORD, 8'd0,   1'b1, 1'b1, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd255, 1'b0, 1'b1, 8'd255, 13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'h5a,  1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_REGS, 8'd0, 1'b0, 1'b0, 8'd0, LineWidthRst, FrameHeightRst, 1'b0, 9'd0, 8'd255},
    '{ROW_WORD, 8'd255, 1'b0, 1'b1, 8'd255, 13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd0,   1'b0, 1'b1, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_REGS, 8'd0, 1'b0, 1'b0, 8'd0, LineWidthRst, FrameHeightRst, 1'b0, 9'd256, 8'd0},
    '{ROW_WORD, 8'h3c,  1'b0, 1'b1, 8'd192, 13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'hc3,  1'b0, 1'b1, 8'd192, 13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    // 2x6 frame, deinterlacing on: odd rows 1 and 3 held, row 5 passed straight
    '{ROW_REGS, 8'd0,   1'b0, 1'b0, 8'd0,   13'd2, 13'd6, 1'b1, 9'd128, 8'd32},
    '{ROW_WORD, 8'd100, 1'b1, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd200, 1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd10,  1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd150, 1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd120, 1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd200, 1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd115, 1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd60,  1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd100, 1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd60,  1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd7,   1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd9,   1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    // zero width and height clamp to a 1x1 frame
    '{ROW_REGS, 8'd0,   1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd128, 8'd32},
    '{ROW_WORD, 8'd1,   1'b0, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0},
    '{ROW_WORD, 8'd2,   1'b1, 1'b0, 8'd0,   13'd0, 13'd0, 1'b0, 9'd0, 8'd0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = CFG_LINE_WIDTH;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [7:0]          pixel_in_i    = '0;
  logic                frame_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [7:0]          pixel_out_o;
  logic [11:0]         out_row_o;
  logic [11:0]         out_column_o;
  logic                last_of_item_o;
  logic                last_of_frame_o;

  // predictor state
  logic [12:0] reg_width  = LineWidthRst;
  logic [12:0] reg_height = FrameHeightRst;
  logic        reg_di     = 1'b0;
  logic [8:0]  reg_bright = BrightnessRst;
  logic [7:0]  reg_gain   = GainRst;
  logic [7:0]  even_line [MaxLine];
  logic [7:0]  odd_line  [MaxLine];
  int unsigned col_at = 0;
  int unsigned row_at = 0;

  sample_t     pending_samples [$];
  int unsigned faults = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  deinterlace_bright_contrast #(.MAX_LINE_WIDTH(MaxLine)) uut (.*);

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] tone_map(input logic [7:0] x);
    int b;
    int v;
    b = int'(reg_bright);
    v = ((int'(x) + ((b - 384) >>> 1)) * int'(reg_gain) + (((b + 128) >> 1) << 5)) >>> 5;
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // append one expected word at the tail of the queue
  function automatic void queue_expected(input sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  function automatic void line_average_step(input logic [7:0] pix, input logic fs);
    int unsigned w, h, row, col, pairs_end, avg, mid, diff;
    logic        lf;
    w = (reg_width == 0) ? 1 : ((reg_width > MaxLine) ? MaxLine : int'(reg_width));
    h = (reg_height == 0) ? 1 : ((reg_height > 4096) ? 4096 : int'(reg_height));
    if (fs) begin
      col_at = 0;
      row_at = 0;
    end
    if (col_at >= w) col_at = 0;
    row       = row_at;
    col       = col_at;
    pairs_end = 2 * (h / 2);
    lf        = (row >= h - 1) && (col == w - 1);
    if (row[0]) begin
      if (reg_di && row + 3 <= pairs_end) begin
        odd_line[col] = pix;
      end else begin
        queue_expected(sample_t'{tone_map(pix), row[11:0], col[11:0], 1'b1, lf});
      end
    end else begin
      if (reg_di && row >= 2 && row + 2 <= pairs_end) begin
        avg  = int'(even_line[col] >> 1) + int'(pix >> 1);
        mid  = int'(odd_line[col]);
        diff = (avg > mid) ? avg - mid : mid - avg;
        if (diff >= 16) mid = avg;
        queue_expected(
          sample_t'{tone_map(mid[7:0]), 12'(row - 1), col[11:0], 1'b0, 1'b0});
      end
      even_line[col] = pix;
      queue_expected(sample_t'{tone_map(pix), row[11:0], col[11:0], 1'b1, lf});
    end
    if (col + 1 >= w) begin
      col_at = 0;
      row_at = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_at = col + 1;
    end
  endfunction

  // valid stays high across back-to-back words; only a gap lowers it
  task automatic send_word(input logic [7:0] pix, input logic fs);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_in_i    <= pix;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    line_average_step(pix, fs);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LINE_WIDTH:    reg_width  = val;
      CFG_FRAME_HEIGHT:  reg_height = val;
      CFG_DEINTERLACE:   reg_di     = val[0];
      CFG_BRIGHTNESS:    reg_bright = val[8:0];
      CFG_CONTRAST_GAIN: reg_gain   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [12:0] w, input logic [12:0] h, input logic di,
                           input logic [8:0] b, input logic [7:0] g);
    drain();
    put_reg(CFG_LINE_WIDTH, w);
    put_reg(CFG_FRAME_HEIGHT, h);
    put_reg(CFG_DEINTERLACE, {12'd0, di});
    put_reg(CFG_BRIGHTNESS, {4'd0, b});
    put_reg(CFG_CONTRAST_GAIN, {5'd0, g});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_pixel();
    // a narrow band makes small line-average differences common
    return ($urandom_range(2) == 0) ? 8'($urandom) : 8'(100 + $urandom_range(40));
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < IdlePct);

  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual pixel %0d row %0d col %0d",
                 $time, pixel_out_o, out_row_o, out_column_o);
        faults++;
      end else begin
        want = pending_samples.pop_front();
        check_field("pixel_out", want.pix, pixel_out_o);
        check_field("out_row", want.row, out_row_o);
        check_field("out_column", want.col, out_column_o);
        check_field("last_of_item", want.last_item, last_of_item_o);
        check_field("last_of_frame", want.last_frame, last_of_frame_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: watchdog, no handshake for %0d cycles, %0d words still due",
               $time, WatchdogLimit, pending_samples.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [12:0] w, h;
    logic        di;
    logic [8:0]  b;
    logic [7:0]  g;
    logic        fs;
    for (int i = 0; i < MaxLine; i++) begin
      even_line[i] = '0;
      odd_line[i]  = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Script[i]) begin
      if (Script[i].kind == ROW_REGS) begin
        load_regs(Script[i].width, Script[i].height, Script[i].di, Script[i].bright,
                  Script[i].gain);
      end else begin
        send_word(Script[i].pix, Script[i].fs);
        if (Script[i].typed) pending_samples[$].pix = Script[i].want;
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      case ($urandom_range(9))
        0:       w = 13'd0;
        1:       w = 13'd8191;
        2, 3:    w = 13'($urandom_range(40, 13));
        default: w = 13'($urandom_range(12, 1));
      endcase
      case ($urandom_range(7))
        0:       h = 13'd0;
        1:       h = 13'd4096;
        default: h = 13'($urandom_range(9, 1));
      endcase
      di = ($urandom_range(3) != 0);
      case ($urandom_range(5))
        0:       b = 9'd0;
        1:       b = 9'd256;
        2:       b = BrightnessRst;
        default: b = 9'($urandom_range(256));
      endcase
      case ($urandom_range(5))
        0:       g = 8'd0;
        1:       g = 8'd255;
        2:       g = GainRst;
        default: g = 8'($urandom);
      endcase
      load_regs(w, h, di, b, g);
      calm = (p == CalmPhase);
      for (int i = 0; i < PhaseWords; i++) begin
        // mark frame starts mostly where the frame really begins, rarely elsewhere
        if (i == 0) fs = 1'b1;
        else if (col_at == 0 && row_at == 0) fs = 1'($urandom_range(1));
        else fs = ($urandom_range(49) == 0);
        send_word(pick_pixel(), fs);
      end
    end
    calm = 1'b0;

    drain();
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
